/* rtl/spfs_pkg.sv */
package spfs_pkg;

    localparam int unsigned PHASE_W = 9;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [PHASE_W-1:0] PH_EYE_B_LOW   = 9'd40;
    localparam logic [PHASE_W-1:0] PH_SYNC_HIGH   = 9'd180;
    localparam logic [PHASE_W-1:0] PH_EYE_B_HIGH  = 9'd200;
    localparam logic [PHASE_W-1:0] PH_SEND_FIRST  = 9'd210;
    localparam logic [PHASE_W-1:0] PH_EYE_A_LOW   = 9'd240;
    localparam logic [PHASE_W-1:0] PH_SEND_SECOND = 9'd252;
    localparam logic [PHASE_W-1:0] PH_SYNC_LOW    = 9'd380;
    localparam logic [PHASE_W-1:0] PH_FRAME_END   = 9'd400;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

    localparam logic [BYTE_W-1:0] FRAME_VALUE_RESET = 8'hA4;

    // Register indexes of the configuration port.
    localparam logic REG_FRAME_VALUE = 1'b0;

    // Levels and events produced by the phase unit for one tick.
    typedef struct packed {
        logic start;
        logic eye_a;
        logic eye_b;
        logic sync;
    } phase_evt_t;

    // Serial line levels after one tick.
    typedef struct packed {
        logic clock;
        logic data;
    } ser_lines_t;

endpackage

/* rtl/spfs_phase.sv */
module spfs_phase import spfs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    output phase_evt_t evt_next
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] phase_inc;
    logic               eye_a_reg, eye_a_next;
    logic               eye_b_reg, eye_b_next;
    logic               sync_reg, sync_next;
    logic               start;

    always_comb begin
        phase_inc  = phase_reg + 1'b1;
        phase_next = phase_reg;
        eye_a_next = eye_a_reg;
        eye_b_next = eye_b_reg;
        sync_next  = sync_reg;
        start      = 1'b0;
        if (advance) begin
            phase_next = phase_inc;
            unique case (phase_inc)
                PH_EYE_B_LOW:   eye_b_next = 1'b0;
                PH_SYNC_HIGH:   sync_next  = 1'b1;
                PH_EYE_B_HIGH:  eye_b_next = 1'b1;
                PH_SEND_FIRST:  start      = 1'b1;
                PH_EYE_A_LOW:   eye_a_next = 1'b0;
                PH_SEND_SECOND: start      = 1'b1;
                PH_SYNC_LOW:    sync_next  = 1'b0;
                PH_FRAME_END: begin
                    eye_a_next = 1'b1;
                    phase_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            eye_a_reg <= 1'b0;
            eye_b_reg <= 1'b0;
            sync_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            eye_a_reg <= eye_a_next;
            eye_b_reg <= eye_b_next;
            sync_reg  <= sync_next;
        end
    end

    assign evt_next = '{start: start, eye_a: eye_a_next, eye_b: eye_b_next, sync: sync_next};

endmodule

/* rtl/spfs_ser.sv */
module spfs_ser import spfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              start,
    input  logic [BYTE_W-1:0] frame_value,
    output ser_lines_t        lines_next
);

    logic [STEP_W-1:0] step_reg, step_next, step_cur;
    logic              sending_reg, sending_next, sending_cur;
    logic [BYTE_W-1:0] shift_reg, shift_next, shift_cur;
    logic              clock_reg, clock_next;
    logic              data_reg, data_next;

    always_comb begin
        // A start reloads the step and the byte, then the first step runs in the same tick.
        step_cur    = start ? '0 : step_reg;
        sending_cur = start | sending_reg;
        shift_cur   = start ? frame_value : shift_reg;

        step_next    = step_reg;
        sending_next = sending_reg;
        shift_next   = shift_reg;
        clock_next   = clock_reg;
        data_next    = data_reg;
        if (advance) begin
            step_next    = step_cur;
            sending_next = sending_cur;
            shift_next   = shift_cur;
            if (sending_cur) begin
                if (step_cur[0]) begin
                    clock_next = 1'b1;
                end else begin
                    clock_next = 1'b0;
                    data_next  = shift_cur[BYTE_W-1];
                    shift_next = {shift_cur[BYTE_W-2:0], 1'b0};
                end
                if (step_cur == LAST_STEP) begin
                    sending_next = 1'b0;
                end else begin
                    step_next = step_cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            sending_reg <= 1'b0;
            shift_reg   <= '0;
            clock_reg   <= 1'b0;
            data_reg    <= 1'b0;
        end else begin
            step_reg    <= step_next;
            sending_reg <= sending_next;
            shift_reg   <= shift_next;
            clock_reg   <= clock_next;
            data_reg    <= data_next;
        end
    end

    assign lines_next = '{clock: clock_next, data: data_next};

endmodule

/* rtl/sync_phase_and_frame_serializer_top.sv */
// Sync phase generator and frame-value serializer.
//
// Each input transaction on s_* carries one tick flag in s_tdata[0]. A tick of one
// advances a 400-step frame counter that drives the eye A, eye B and main sync
// levels, and twice per frame starts sending frame_value MSB first on the
// serial clock and data lines over 17 ticks. A tick of zero changes nothing.
// Every input transaction yields exactly one output transaction on m_* with
// the levels after that tick.
//
// The result is registered: it is in the output register on the cycle
// after the input is accepted. One transaction per cycle is sustained
// unless the receiver stalls; state update and result capture both
// happen on the accept edge. When the receiver stalls, the output register
// holds and s_tready drops until the result is taken, so nothing is lost.
//
// Reset (aresetn low, synchronous) clears all levels and the counter and
// loads frame_value with 0xA4. frame_value sits at APB address 0 and is
// sampled whenever a transmission starts.
module sync_phase_and_frame_serializer_top import spfs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] eye_a_sync, [1] eye_b_sync, [2] main_sync,
                                   // [3] serial_clock, [4] serial_data, [7:5] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BYTE_W-1:0] frame_value_reg;
    logic              m_tvalid_reg;
    logic [4:0]        result_reg;
    logic              accept;
    logic              advance;
    phase_evt_t        evt_next;
    ser_lines_t        lines_next;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FRAME_VALUE) ? {24'd0, frame_value_reg} : 32'd0;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign advance  = accept && s_tdata[0];

    spfs_phase u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .evt_next (evt_next)
    );

    spfs_ser u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .start       (evt_next.start),
        .frame_value (frame_value_reg),
        .lines_next  (lines_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_value_reg <= FRAME_VALUE_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_VALUE) begin
                frame_value_reg <= pwdata[BYTE_W-1:0];
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= {lines_next.data, lines_next.clock, evt_next.sync,
                           evt_next.eye_b, evt_next.eye_a};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, result_reg};

endmodule
